### hdl/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned MaxOut = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    PhIdle,
    PhPct,
    PhDigit
  } phase_e;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [1:0]             count;
    logic                   last;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) ||
        ((c >= 8'h41) && (c <= 8'h46)) ||
        ((c >= 8'h61) && (c <= 8'h66));
    return r;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] r;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r = c[3:0];
    end else begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

### hdl/url_percent_decoder.sv
// URL percent decoder: takes one encoded byte per request and returns the decoded
// bytes, turning a percent sign and two hex digits into one byte and a plus into a
// space, sending a broken or unfinished escape literally, and marking the final
// decoded byte of each string with tlast. An input byte yields zero to three output
// bytes; the input side takes one byte per cycle while the four-entry queue between
// the classifier and the output serializer has room, and the serializer sends one
// byte per cycle while the queue holds an entry and the output is ready. With the
// queue empty and the output free, the first decoded byte of a request passes through
// a queue entry and then the output register before it is presented.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  upd_pkg::entry_t entry;
  upd_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  upd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .entry_o (entry)
  );

  upd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule

### hdl/upd_front.sv
module upd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic                full_i,
  output logic                ready_o,
  output logic                push_o,
  output upd_pkg::entry_t     entry_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [7:0]      em [upd_pkg::MaxOut];
  logic [1:0]      n;
  logic            fresh;
  logic            hex;
  logic            accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign hex     = upd_pkg::is_hex(byte_i);

  always_comb begin
    n       = 2'd0;
    fresh   = 1'b0;
    phase_d = phase_q;
    held_d  = held_q;
    for (int i = 0; i < upd_pkg::MaxOut; i++) begin
      em[i] = 8'h00;
    end

    unique case (phase_q)
      upd_pkg::PhPct: begin
        if (hex) begin
          held_d  = byte_i;
          phase_d = upd_pkg::PhDigit;
        end else begin
          em[0] = upd_pkg::ChPercent;
          n     = 2'd1;
          fresh = 1'b1;
        end
      end
      upd_pkg::PhDigit: begin
        if (hex) begin
          em[0]   = {upd_pkg::hex_value(held_q), upd_pkg::hex_value(byte_i)};
          n       = 2'd1;
          phase_d = upd_pkg::PhIdle;
        end else begin
          em[0] = upd_pkg::ChPercent;
          em[1] = held_q;
          n     = 2'd2;
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      if (byte_i == upd_pkg::ChPercent) begin
        phase_d = upd_pkg::PhPct;
      end else begin
        em[n]   = (byte_i == upd_pkg::ChPlus) ? upd_pkg::ChSpace : byte_i;
        n       = n + 2'd1;
        phase_d = upd_pkg::PhIdle;
      end
    end

    if (last_i) begin
      if (phase_d == upd_pkg::PhPct) begin
        em[n] = upd_pkg::ChPercent;
        n     = n + 2'd1;
      end else if (phase_d == upd_pkg::PhDigit) begin
        em[0] = upd_pkg::ChPercent;
        em[1] = held_d;
        n     = 2'd2;
      end
      phase_d = upd_pkg::PhIdle;
    end
  end

  always_comb begin
    for (int i = 0; i < upd_pkg::MaxOut; i++) begin
      entry_o.bytes[i] = em[i];
    end
    entry_o.count = n;
    entry_o.last  = last_i;
    push_o        = accept && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PhIdle;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

### hdl/upd_queue.sv
module upd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upd_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output upd_pkg::entry_t head_o
);

  upd_pkg::entry_t           mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (upd_pkg::QPtrW+1)'(upd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Request pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Request popped from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> entry_i.count != 2'd0)
    else $error("Queued request carries no bytes.");

endmodule

### hdl/upd_back.sv
module upd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  upd_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;
  logic       take;
  logic       final_byte;

  assign load       = !valid_q || ready_i;
  assign take       = load && !empty_i;
  assign final_byte = (idx_q == (head_i.count - 2'd1));
  assign pop_o      = take && final_byte;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= head_i.last && final_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule
